### design/ifg_pkg.sv
// Shared types, register map and pixel helpers for the image flip/grayscale block.
package ifg_pkg;

    localparam int SIZE_W  = 9;
    localparam int CHAN_W  = 8;
    localparam int PIX_W   = 3 * CHAN_W;
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    typedef enum logic [2:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_MIRROR_VERT  = 3'd2,
        REG_MIRROR_HORIZ = 3'd3,
        REG_GRAY_ENABLE  = 3'd4
    } reg_index_t;

    localparam logic [SIZE_W-1:0] FRAME_WIDTH_RST  = 9'd256;
    localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RST = 9'd256;

    typedef struct packed {
        logic [SIZE_W-1:0] frame_width;
        logic [SIZE_W-1:0] frame_height;
        logic              mirror_vertical;
        logic              mirror_horizontal;
        logic              gray_enable;
        logic              size_write;
    } cfg_t;

    // floor((r+g+b)/3) via reciprocal 683/2048, exact for sums up to 765
    function automatic logic [CHAN_W-1:0] avg3(input logic [CHAN_W-1:0] r,
                                               input logic [CHAN_W-1:0] g,
                                               input logic [CHAN_W-1:0] b);
        logic [9:0]  sum;
        logic [19:0] prod;
        sum  = 10'(r) + 10'(g) + 10'(b);
        prod = 20'(sum) * 20'd683;
        return prod[18:11];
    endfunction

endpackage

### design/ifg_regs.sv
// APB configuration registers for the image flip/grayscale block.
module ifg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ifg_pkg::PADDR_W-1:0]   paddr,
    input  logic [ifg_pkg::PDATA_W-1:0]   pwdata,
    output logic [ifg_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output ifg_pkg::cfg_t                 cfg
);
    import ifg_pkg::*;

    logic [SIZE_W-1:0] frame_width_reg;
    logic [SIZE_W-1:0] frame_height_reg;
    logic              mirror_vertical_reg;
    logic              mirror_horizontal_reg;
    logic              gray_enable_reg;
    logic              wr_en;
    reg_index_t        idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_index_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            frame_width_reg       <= FRAME_WIDTH_RST;
            frame_height_reg      <= FRAME_HEIGHT_RST;
            mirror_vertical_reg   <= 1'b1;
            mirror_horizontal_reg <= 1'b1;
            gray_enable_reg       <= 1'b1;
        end else begin
            if (wr_en) begin
                case (idx)
                    REG_FRAME_WIDTH:  frame_width_reg       <= pwdata[SIZE_W-1:0];
                    REG_FRAME_HEIGHT: frame_height_reg      <= pwdata[SIZE_W-1:0];
                    REG_MIRROR_VERT:  mirror_vertical_reg   <= pwdata[0];
                    REG_MIRROR_HORIZ: mirror_horizontal_reg <= pwdata[0];
                    REG_GRAY_ENABLE:  gray_enable_reg       <= pwdata[0];
                    default: ;
                endcase
            end
        end
    end

    always_comb
    begin
        case (idx)
            REG_FRAME_WIDTH:  prdata = PDATA_W'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = PDATA_W'(frame_height_reg);
            REG_MIRROR_VERT:  prdata = PDATA_W'(mirror_vertical_reg);
            REG_MIRROR_HORIZ: prdata = PDATA_W'(mirror_horizontal_reg);
            REG_GRAY_ENABLE:  prdata = PDATA_W'(gray_enable_reg);
            default:          prdata = '0;
        endcase
    end

    assign cfg.frame_width       = frame_width_reg;
    assign cfg.frame_height      = frame_height_reg;
    assign cfg.mirror_vertical   = mirror_vertical_reg;
    assign cfg.mirror_horizontal = mirror_horizontal_reg;
    assign cfg.gray_enable       = gray_enable_reg;
    // clear the raster counters at the same edge as a size write
    assign cfg.size_write        = wr_en &&
                                   (idx == REG_FRAME_WIDTH || idx == REG_FRAME_HEIGHT);

endmodule

### design/image_flip_grayscale.sv
// Frame flip engine: stores a frame, then streams it back, optionally mirrored and grayscale.
// Pipeline: a fetch reads the frame store into stage one, then the result register.
// Throughput: one request per cycle unless pixel_stall holds it off; the frame store has one write and one read port.
// Reset: counters return to row 0, column 0 and config takes its reset values;
// the frame store is not cleared and holds unknown data until written.
module image_flip_grayscale #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ifg_pkg::PADDR_W-1:0]   paddr,
    input  logic [ifg_pkg::PDATA_W-1:0]   pwdata,
    output logic [ifg_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          pixel_valid,
    output logic                          pixel_stall,
    input  logic                          action,
    input  logic [ifg_pkg::CHAN_W-1:0]    red_in,
    input  logic [ifg_pkg::CHAN_W-1:0]    green_in,
    input  logic [ifg_pkg::CHAN_W-1:0]    blue_in,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [ifg_pkg::CHAN_W-1:0]    red_out,
    output logic [ifg_pkg::CHAN_W-1:0]    green_out,
    output logic [ifg_pkg::CHAN_W-1:0]    blue_out,
    output logic                          frame_last
);
    import ifg_pkg::*;

    localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WS_W  = $clog2(MAX_WIDTH + 1);
    localparam int HS_W  = $clog2(MAX_HEIGHT + 1);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    cfg_t cfg;

    ifg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // effective frame size: zero acts as one, oversize clamps to the maximum
    logic [WS_W-1:0] w_eff;
    logic [HS_W-1:0] h_eff;

    always_comb
    begin
        if (cfg.frame_width == '0)
            w_eff = WS_W'(1);
        else if (32'(cfg.frame_width) > 32'(MAX_WIDTH))
            w_eff = WS_W'(MAX_WIDTH);
        else
            w_eff = WS_W'(cfg.frame_width);
        if (cfg.frame_height == '0)
            h_eff = HS_W'(1);
        else if (32'(cfg.frame_height) > 32'(MAX_HEIGHT))
            h_eff = HS_W'(MAX_HEIGHT);
        else
            h_eff = HS_W'(cfg.frame_height);
    end

    logic [RW-1:0] store_row_reg, store_row_next;
    logic [CW-1:0] store_col_reg, store_col_next;
    logic [RW-1:0] fetch_row_reg, fetch_row_next;
    logic [CW-1:0] fetch_col_reg, fetch_col_next;

    logic s1_valid_reg;
    logic [PIX_W-1:0] s1_pix_reg;
    logic s1_last_reg;
    logic out_valid_reg;
    logic [CHAN_W-1:0] red_out_reg, green_out_reg, blue_out_reg;
    logic frame_last_reg;

    logic out_free;
    logic pix_acc, store_acc, fetch_acc;
    logic store_col_end, store_row_end, fetch_col_end, fetch_row_end;
    logic [RW-1:0] src_row;
    logic [CW-1:0] src_col;
    logic [AW-1:0] wr_addr, rd_addr;

    assign out_free    = !out_valid_reg || !result_stall;
    assign pixel_stall = s1_valid_reg && !out_free;
    assign pix_acc     = pixel_valid && !pixel_stall;
    assign store_acc   = pix_acc && !action;
    assign fetch_acc   = pix_acc && action;

    assign store_col_end = (32'(store_col_reg) + 32'd1 >= 32'(w_eff));
    assign store_row_end = (32'(store_row_reg) + 32'd1 >= 32'(h_eff));
    assign fetch_col_end = (32'(fetch_col_reg) + 32'd1 >= 32'(w_eff));
    assign fetch_row_end = (32'(fetch_row_reg) + 32'd1 >= 32'(h_eff));

    always_comb
    begin
        store_row_next = store_row_reg;
        store_col_next = store_col_reg;
        fetch_row_next = fetch_row_reg;
        fetch_col_next = fetch_col_reg;
        if (store_acc) begin
            if (store_col_end) begin
                store_col_next = '0;
                store_row_next = store_row_end ? '0 : store_row_reg + 1'b1;
            end else begin
                store_col_next = store_col_reg + 1'b1;
            end
        end
        if (fetch_acc) begin
            if (fetch_col_end) begin
                fetch_col_next = '0;
                fetch_row_next = fetch_row_end ? '0 : fetch_row_reg + 1'b1;
            end else begin
                fetch_col_next = fetch_col_reg + 1'b1;
            end
        end
    end

    // mirrored source position of the current fetch
    assign src_row = cfg.mirror_vertical
                   ? RW'(32'(h_eff) - 32'd1 - 32'(fetch_row_reg)) : fetch_row_reg;
    assign src_col = cfg.mirror_horizontal
                   ? CW'(32'(w_eff) - 32'd1 - 32'(fetch_col_reg)) : fetch_col_reg;

    assign wr_addr = AW'(32'(store_row_reg) * 32'(MAX_WIDTH) + 32'(store_col_reg));
    assign rd_addr = AW'(32'(src_row) * 32'(MAX_WIDTH) + 32'(src_col));

    logic [PIX_W-1:0] frame_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (store_acc)
            frame_mem[wr_addr] <= {red_in, green_in, blue_in};
        if (fetch_acc) begin
            s1_pix_reg  <= frame_mem[rd_addr];
            s1_last_reg <= fetch_col_end && fetch_row_end;
        end
        if (out_free && s1_valid_reg) begin
            if (cfg.gray_enable) begin
                red_out_reg   <= avg3(s1_pix_reg[23:16], s1_pix_reg[15:8], s1_pix_reg[7:0]);
                green_out_reg <= avg3(s1_pix_reg[23:16], s1_pix_reg[15:8], s1_pix_reg[7:0]);
                blue_out_reg  <= avg3(s1_pix_reg[23:16], s1_pix_reg[15:8], s1_pix_reg[7:0]);
            end else begin
                red_out_reg   <= s1_pix_reg[23:16];
                green_out_reg <= s1_pix_reg[15:8];
                blue_out_reg  <= s1_pix_reg[7:0];
            end
            frame_last_reg <= s1_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            store_row_reg <= '0;
            store_col_reg <= '0;
            fetch_row_reg <= '0;
            fetch_col_reg <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg.size_write) begin
                store_row_reg <= '0;
                store_col_reg <= '0;
                fetch_row_reg <= '0;
                fetch_col_reg <= '0;
            end else begin
                store_row_reg <= store_row_next;
                store_col_reg <= store_col_next;
                fetch_row_reg <= fetch_row_next;
                fetch_col_reg <= fetch_col_next;
            end
            // hold stage one while the result register is blocked
            if (fetch_acc)
                s1_valid_reg <= 1'b1;
            else if (out_free)
                s1_valid_reg <= 1'b0;
            if (out_free)
                out_valid_reg <= s1_valid_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign red_out      = red_out_reg;
    assign green_out    = green_out_reg;
    assign blue_out     = blue_out_reg;
    assign frame_last   = frame_last_reg;

endmodule

### dv/tb_top.sv
// Testbench for image_flip_grayscale: directed request table, then random frames.
module tb_top;
    import ifg_pkg::*;

    localparam int         STORE_DIM    = 256;
    localparam logic       ACT_STORE    = 1'b0;
    localparam logic       ACT_FETCH    = 1'b1;
    localparam logic [2:0] REG_UNMAPPED = 3'd7;
    localparam int         RANDOM_ITEMS = 2000;
    localparam int         QUIET_LIMIT  = 5000;
    localparam int         SETTLE       = 4;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              last;
    } out_pix_t;

    typedef struct packed {
        bit                is_reg;
        logic [2:0]        idx;
        logic [31:0]       val;
        logic              act;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        bit                typed;
        out_pix_t          want;
    } script_row_t;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                psel         = 1'b0;
    logic                penable      = 1'b0;
    logic                pwrite       = 1'b0;
    logic [PADDR_W-1:0]  paddr        = '0;
    logic [PDATA_W-1:0]  pwdata       = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                pixel_valid  = 1'b0;
    logic                pixel_stall;
    logic                action       = ACT_STORE;
    logic [CHAN_W-1:0]   red_in       = '0;
    logic [CHAN_W-1:0]   green_in     = '0;
    logic [CHAN_W-1:0]   blue_in      = '0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    logic [CHAN_W-1:0]   red_out;
    logic [CHAN_W-1:0]   green_out;
    logic [CHAN_W-1:0]   blue_out;
    logic                frame_last;

    image_flip_grayscale dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .action       (action),
        .red_in       (red_in),
        .green_in     (green_in),
        .blue_in      (blue_in),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .red_out      (red_out),
        .green_out    (green_out),
        .blue_out     (blue_out),
        .frame_last   (frame_last)
    );

    always #5 clk = ~clk;

    // Predictor state: configuration, raster counters and the frame store image
    logic [SIZE_W-1:0] cfg_width    = FRAME_WIDTH_RST;
    logic [SIZE_W-1:0] cfg_height   = FRAME_HEIGHT_RST;
    logic              cfg_mirror_v = 1'b1;
    logic              cfg_mirror_h = 1'b1;
    logic              cfg_gray     = 1'b1;
    int                st_row = 0, st_col = 0, fe_row = 0, fe_col = 0;
    logic [PIX_W-1:0]  frame_mem     [STORE_DIM*STORE_DIM];
    bit                frame_written [STORE_DIM*STORE_DIM];

    out_pix_t pending_pixels[$];
    int       bad_fields   = 0;
    int       items_sent   = 0;
    int       tx_idle_pct  = 0;
    int       rx_idle_pct  = 0;
    int       quiet_cycles = 0;

    function automatic int eff_size(logic [SIZE_W-1:0] v);
        if (v == 0)
            return 1;
        return (v > STORE_DIM) ? STORE_DIM : int'(v);
    endfunction

    function automatic void next_pos(inout int row, inout int col, input int w, input int h);
        if (col + 1 >= w) begin
            col = 0;
            row = (row + 1 >= h) ? 0 : row + 1;
        end else begin
            col = col + 1;
        end
    endfunction

    // Fold stray counters back to the origin, then return the mirrored source of the next fetch.
    function automatic int fetch_addr();
        int w, h, row, col;
        w = eff_size(cfg_width);
        h = eff_size(cfg_height);
        if (st_row >= h || st_col >= w || fe_row >= h || fe_col >= w) begin
            st_row = 0;
            st_col = 0;
            fe_row = 0;
            fe_col = 0;
        end
        row = cfg_mirror_v ? (h - 1 - fe_row) : fe_row;
        col = cfg_mirror_h ? (w - 1 - fe_col) : fe_col;
        return row * STORE_DIM + col;
    endfunction

    function automatic bit predict_flip(logic act, logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                                        logic [CHAN_W-1:0] b, output out_pix_t p);
        int               w, h, src;
        logic [PIX_W-1:0] pix;
        logic [9:0]       avg;
        p   = '0;
        src = fetch_addr();
        w   = eff_size(cfg_width);
        h   = eff_size(cfg_height);
        if (act == ACT_STORE) begin
            frame_mem[st_row * STORE_DIM + st_col]     = {r, g, b};
            frame_written[st_row * STORE_DIM + st_col] = 1'b1;
            next_pos(st_row, st_col, w, h);
            return 1'b0;
        end
        pix     = frame_mem[src];
        p.red   = pix[23:16];
        p.green = pix[15:8];
        p.blue  = pix[7:0];
        if (cfg_gray) begin
            avg     = (10'(pix[23:16]) + 10'(pix[15:8]) + 10'(pix[7:0])) / 10'd3;
            p.red   = avg[7:0];
            p.green = avg[7:0];
            p.blue  = avg[7:0];
        end
        p.last = (fe_row == h - 1) && (fe_col == w - 1);
        next_pos(fe_row, fe_col, w, h);
        return 1'b1;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            bad_fields++;
        end
    endfunction

    // Receiver: random stall, compare each accepted result with the oldest prediction
    always @(posedge clk) begin
        out_pix_t want;
        result_stall <= ($urandom_range(99) < rx_idle_pct);
        if (rst_n && result_valid === 1'b1 && result_stall == 1'b0) begin
            if (pending_pixels.size() == 0) begin
                $error("result with no request pending: red_out %0d green_out %0d blue_out %0d",
                       red_out, green_out, blue_out);
                bad_fields++;
            end else begin
                want = pending_pixels.pop_front();
                check_field("red_out", 32'(want.red), 32'(red_out));
                check_field("green_out", 32'(want.green), 32'(green_out));
                check_field("blue_out", 32'(want.blue), 32'(blue_out));
                check_field("frame_last", 32'(want.last), 32'(frame_last));
            end
        end
    end

    always @(posedge clk) begin
        if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall) ||
            (psel && penable && pready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic send_item(logic act, logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                             logic [CHAN_W-1:0] b, bit typed = 1'b0, out_pix_t want = '0);
        out_pix_t p;
        while ($urandom_range(99) < tx_idle_pct) begin
            pixel_valid <= 1'b0;
            @(posedge clk);
        end
        pixel_valid <= 1'b1;
        action      <= act;
        red_in      <= r;
        green_in    <= g;
        blue_in     <= b;
        do @(posedge clk); while (pixel_stall !== 1'b0);
        if (predict_flip(act, r, g, b, p))
            pending_pixels.push_back(typed ? want : p);
        items_sent++;
    endtask

    // Hold the sender until every predicted pixel is back, then let the pipe empty.
    task automatic wait_idle();
        pixel_valid <= 1'b0;
        do @(posedge clk); while (pending_pixels.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic apb_xfer(logic wr, logic [2:0] idx, logic [31:0] wdata,
                            output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        logic [31:0] rd;
        wait_idle();
        apb_xfer(1'b1, idx, val, rd);
        case (idx)
            REG_FRAME_WIDTH, REG_FRAME_HEIGHT:
            begin
                if (idx == REG_FRAME_WIDTH)
                    cfg_width = val[SIZE_W-1:0];
                else
                    cfg_height = val[SIZE_W-1:0];
                st_row = 0;
                st_col = 0;
                fe_row = 0;
                fe_col = 0;
            end
            REG_MIRROR_VERT:  cfg_mirror_v = val[0];
            REG_MIRROR_HORIZ: cfg_mirror_h = val[0];
            REG_GRAY_ENABLE:  cfg_gray     = val[0];
            default: ;
        endcase
        if (idx <= REG_GRAY_ENABLE) begin
            @(posedge clk);
            apb_xfer(1'b0, idx, '0, rd);
            check_field("prdata", (idx == REG_FRAME_WIDTH || idx == REG_FRAME_HEIGHT) ?
                        {23'b0, val[SIZE_W-1:0]} : {31'b0, val[0]}, rd);
        end
    endtask

    function automatic script_row_t reg_row(logic [2:0] idx, logic [31:0] val);
        script_row_t s;
        s        = '0;
        s.is_reg = 1'b1;
        s.idx    = idx;
        s.val    = val;
        return s;
    endfunction

    function automatic script_row_t pix_row(logic act, logic [CHAN_W-1:0] r,
                                            logic [CHAN_W-1:0] g, logic [CHAN_W-1:0] b);
        script_row_t s;
        s       = '0;
        s.act   = act;
        s.red   = r;
        s.green = g;
        s.blue  = b;
        return s;
    endfunction

    // Fetch whose result is plain from the table; its input channels are noise.
    function automatic script_row_t chk_row(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                                            logic [CHAN_W-1:0] b, logic last);
        script_row_t s;
        s       = pix_row(ACT_FETCH, 8'hA5, 8'h5A, 8'hC3);
        s.typed = 1'b1;
        s.want  = '{red: r, green: g, blue: b, last: last};
        return s;
    endfunction

    initial begin
        script_row_t       script[$];
        int                phase, w, h, n, st, fe, frames, mix, stop_at, k, rand_start, done;
        bit                big_frame;
        logic [SIZE_W-1:0] wsz, hsz;

        // Reset setup is 256x256, both mirrors, gray on: only stores are safe until mirrors clear
        script.push_back(pix_row(ACT_STORE, 8'hFF, 8'hFF, 8'hFF));
        script.push_back(pix_row(ACT_STORE, 8'h00, 8'h00, 8'h00));
        script.push_back(pix_row(ACT_STORE, 8'hFF, 8'h00, 8'h00));
        script.push_back(reg_row(REG_MIRROR_VERT, 32'd0));
        script.push_back(reg_row(REG_MIRROR_HORIZ, 32'd0));
        script.push_back(reg_row(REG_UNMAPPED, 32'hFFFF_FFFF));
        script.push_back(chk_row(8'd255, 8'd255, 8'd255, 1'b0));
        script.push_back(chk_row(8'd0, 8'd0, 8'd0, 1'b0));
        script.push_back(chk_row(8'd85, 8'd85, 8'd85, 1'b0));
        script.push_back(reg_row(REG_FRAME_WIDTH, 32'd2));
        script.push_back(reg_row(REG_FRAME_HEIGHT, 32'd2));
        script.push_back(reg_row(REG_GRAY_ENABLE, 32'd0));
        script.push_back(pix_row(ACT_STORE, 8'hFF, 8'hFF, 8'hFF));
        script.push_back(pix_row(ACT_STORE, 8'h00, 8'h00, 8'h00));
        script.push_back(pix_row(ACT_STORE, 8'hAA, 8'h55, 8'h01));
        script.push_back(pix_row(ACT_STORE, 8'h55, 8'hAA, 8'hFE));
        script.push_back(chk_row(8'hFF, 8'hFF, 8'hFF, 1'b0));
        script.push_back(chk_row(8'h00, 8'h00, 8'h00, 1'b0));
        script.push_back(chk_row(8'hAA, 8'h55, 8'h01, 1'b0));
        script.push_back(chk_row(8'h55, 8'hAA, 8'hFE, 1'b1));
        script.push_back(reg_row(REG_MIRROR_VERT, 32'd1));
        script.push_back(reg_row(REG_MIRROR_HORIZ, 32'd1));
        script.push_back(chk_row(8'h55, 8'hAA, 8'hFE, 1'b0));
        script.push_back(chk_row(8'hAA, 8'h55, 8'h01, 1'b0));
        script.push_back(chk_row(8'h00, 8'h00, 8'h00, 1'b0));
        script.push_back(chk_row(8'hFF, 8'hFF, 8'hFF, 1'b1));
        script.push_back(reg_row(REG_MIRROR_HORIZ, 32'd0));
        script.push_back(chk_row(8'hAA, 8'h55, 8'h01, 1'b0));
        script.push_back(chk_row(8'h55, 8'hAA, 8'hFE, 1'b0));
        script.push_back(chk_row(8'hFF, 8'hFF, 8'hFF, 1'b0));
        script.push_back(chk_row(8'h00, 8'h00, 8'h00, 1'b1));
        // zero sizes act as a single pixel frame
        script.push_back(reg_row(REG_FRAME_WIDTH, 32'd0));
        script.push_back(reg_row(REG_FRAME_HEIGHT, 32'd0));
        script.push_back(reg_row(REG_GRAY_ENABLE, 32'd1));
        script.push_back(pix_row(ACT_STORE, 8'h01, 8'h02, 8'hFF));
        script.push_back(chk_row(8'd86, 8'd86, 8'd86, 1'b1));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 14;
        rx_idle_pct = 61;
        foreach (script[i]) begin
            if (script[i].is_reg)
                reg_write(script[i].idx, script[i].val);
            else
                send_item(script[i].act, script[i].red, script[i].green, script[i].blue,
                          script[i].typed, script[i].want);
        end

        rand_start = items_sent;
        phase      = 0;
        while (items_sent - rand_start < RANDOM_ITEMS) begin
            done = items_sent - rand_start;
            if (done < RANDOM_ITEMS / 3) begin
                tx_idle_pct = 14;
                rx_idle_pct = 61;
            end else if (done < 2 * RANDOM_ITEMS / 3) begin
                tx_idle_pct = 61;
                rx_idle_pct = 14;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end

            // a couple of phases at the widest and tallest frames, the rest small
            big_frame = 1'b1;
            case (phase)
                2: begin wsz = 9'd511; hsz = 9'd1;   end
                6: begin wsz = 9'd1;   hsz = 9'd300; end
                default:
                begin
                    big_frame = 1'b0;
                    wsz   = ($urandom_range(9) == 0) ? 9'd0 : 9'($urandom_range(6, 1));
                    hsz   = ($urandom_range(9) == 0) ? 9'd0 : 9'($urandom_range(6, 1));
                end
            endcase
            // keep the old size now and then so a frame runs on across the phase
            if (big_frame || phase < 3 ||
                eff_size(cfg_width) * eff_size(cfg_height) > 36 || $urandom_range(3) != 0) begin
                reg_write(REG_FRAME_WIDTH, {23'($urandom_range(32'h7F)), wsz});
                reg_write(REG_FRAME_HEIGHT, {23'($urandom_range(32'h7F)), hsz});
            end
            reg_write(REG_MIRROR_VERT, $urandom_range(1));
            reg_write(REG_MIRROR_HORIZ, $urandom_range(1));
            reg_write(REG_GRAY_ENABLE, $urandom_range(1));

            w       = eff_size(cfg_width);
            h       = eff_size(cfg_height);
            frames  = big_frame ? 1 : $urandom_range(3, 1);
            n       = w * h * frames;
            stop_at = 2 * n;
            k       = $urandom_range(9);
            if (k <= 6)
                mix = 10;
            else if (k <= 8)
                mix = 50;
            else begin
                mix     = 20;
                stop_at = $urandom_range(2 * n - 1, 1);
            end

            st = 0;
            fe = 0;
            k  = 0;
            while ((st < n || fe < n) && k < stop_at) begin
                if ($urandom_range(99) < 3)
                    wait_idle();
                if (fe < n && (st == n || $urandom_range(99) < mix) &&
                    frame_written[fetch_addr()]) begin
                    send_item(ACT_FETCH, 8'($urandom_range(255)), 8'($urandom_range(255)),
                              8'($urandom_range(255)));
                    fe++;
                end else if (st < n) begin
                    send_item(ACT_STORE, 8'($urandom_range(255)), 8'($urandom_range(255)),
                              8'($urandom_range(255)));
                    st++;
                end else
                    break;
                k++;
            end
            phase++;
        end

        wait_idle();
        if (bad_fields == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
